/* src/cascaded_position_speed_pid_defines.svh */
// Assertion macros shared by the checker of the cascaded position and speed controller.
`ifndef CASCADED_POSITION_SPEED_PID_DEFINES_SVH
`define CASCADED_POSITION_SPEED_PID_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPSP_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cpsp_pkg.sv */
// Package with widths, constants and types of the cascaded position and speed controller.
`timescale 1ns / 1ps

package cpsp_pkg;

  localparam int CHANNELS   = 4;
  localparam int CHAN_W     = 2;
  localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int GAIN_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int SP_W       = 16;
  localparam int ANGLE_W    = 13;
  localparam int SPEED_W    = 16;
  localparam int DRIVE_W    = 16;

  localparam int FRAC_W     = 16;
  localparam int PERR_W     = 17;
  localparam int PDE_W      = PERR_W + 1;
  localparam int PINT_W     = 40;
  localparam int PTGT_W     = 49;
  localparam int SERR_W     = 50;
  localparam int SDE_W      = SERR_W + 1;
  localparam int SINT_W     = 35;

  localparam int OPND_W     = 52;
  localparam int LIMB_LO_W  = 32;
  localparam int MUL_B_W    = LIMB_LO_W + 1;
  localparam int PROD_W     = GAIN_W + 1 + MUL_B_W;
  localparam int ACC_W      = 62;
  localparam int DRV_FULL_W = ACC_W - FRAC_W;

  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POS_KP       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_POS_KI       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_POS_KD       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SPD_KP       = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SPD_KI       = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_SPD_KD       = CFG_IDX_W'(6);

  localparam logic MODE_SPEED_ONLY = 1'b1;

  localparam int POS_BAND = 4;
  localparam logic [GAIN_W-1:0] DECAY_ZERO = GAIN_W'(65016);
  localparam logic [GAIN_W-1:0] DECAY_OUT  = GAIN_W'(59578);

  localparam logic signed [PINT_W-1:0] PINT_MAX = {1'b0, {(PINT_W-1){1'b1}}};
  localparam logic signed [PINT_W-1:0] PINT_MIN = {1'b1, {(PINT_W-1){1'b0}}};
  localparam logic signed [PTGT_W-1:0] PTGT_MAX = {1'b0, {(PTGT_W-1){1'b1}}};
  localparam logic signed [PTGT_W-1:0] PTGT_MIN = {1'b1, {(PTGT_W-1){1'b0}}};
  localparam logic signed [SINT_W-1:0] SINT_LIM = 35'sd8192000000;
  localparam logic signed [SINT_W-1:0] SINT_NEG = -35'sd8192000000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_LIM = 16'sd25000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_NEG = -16'sd25000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POS_ERR,
    ST_POS_SUM,
    ST_POS_KP_LO,
    ST_POS_KP_HI,
    ST_POS_KI_LO,
    ST_POS_KI_HI,
    ST_POS_KD_LO,
    ST_POS_KD_HI,
    ST_POS_DRAIN,
    ST_POS_OUT,
    ST_DEC_DRAIN,
    ST_POS_WB,
    ST_SPD_ERR,
    ST_SPD_SUM,
    ST_SPD_KP_LO,
    ST_SPD_KP_HI,
    ST_SPD_KI_LO,
    ST_SPD_KI_HI,
    ST_SPD_KD_LO,
    ST_SPD_KD_HI,
    ST_SPD_DRAIN,
    ST_FINAL,
    ST_DONE
  } cpsp_state_e;

  typedef struct packed {
    logic issue;
    logic hi;
    logic clr;
  } cpsp_mac_op_t;

  typedef struct packed {
    logic                     pos_err_we;
    logic                     pos_int_we;
    logic                     spd_we;
    logic signed [PERR_W-1:0] pos_err;
    logic signed [PINT_W-1:0] pos_int;
    logic signed [SERR_W-1:0] spd_err;
    logic signed [SINT_W-1:0] spd_int;
  } cpsp_wr_t;

  typedef struct packed {
    logic signed [PERR_W-1:0] pos_err;
    logic signed [PINT_W-1:0] pos_int;
    logic signed [SERR_W-1:0] spd_err;
    logic signed [SINT_W-1:0] spd_int;
  } cpsp_rd_t;

endpackage

/* src/cpsp_mac.sv */
// Shared gain multiplier with a registered product and a fixed-point accumulator.
`timescale 1ns / 1ps

module cpsp_mac import cpsp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cpsp_mac_op_t            op_i,
  input  logic [GAIN_W-1:0]       gain_i,
  input  logic signed [OPND_W-1:0] opnd_i,
  output logic signed [ACC_W-1:0] acc_o,
  output logic                    frac_o
);

  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      prod_vld_q;
  logic                      prod_hi_q;
  logic                      prod_clr_q;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   acc_base;
  logic signed [ACC_W-1:0]   acc_d;
  logic signed [ACC_W-1:0]   acc_q;
  logic                      frac_d;
  logic                      frac_q;

  // The operand is split into an unsigned low limb and a signed high limb.
  always_comb begin
    if (op_i.hi) begin
      mul_b = MUL_B_W'($signed(opnd_i[OPND_W-1:LIMB_LO_W]));
    end else begin
      mul_b = $signed({1'b0, opnd_i[LIMB_LO_W-1:0]});
    end
    prod = $signed({1'b0, gain_i}) * mul_b;
  end

  always_comb begin
    if (prod_hi_q) begin
      term = ACC_W'(prod_q) <<< FRAC_W;
    end else begin
      term = ACC_W'(prod_q >>> FRAC_W);
    end
    acc_base = prod_clr_q ? '0 : acc_q;
    acc_d    = prod_vld_q ? acc_base + term : acc_q;
    frac_d   = (prod_vld_q && !prod_hi_q) ? |prod_q[FRAC_W-1:0] : frac_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= op_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod;
    prod_hi_q  <= op_i.hi;
    prod_clr_q <= op_i.clr;
    acc_q      <= acc_d;
    frac_q     <= frac_d;
  end

  assign acc_o  = acc_q;
  assign frac_o = frac_q;

endmodule

/* src/cpsp_chan_state.sv */
// Per-channel loop state: last errors and integrals of both loops.
`timescale 1ns / 1ps

module cpsp_chan_state import cpsp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CHAN_IDX_W-1:0] idx_i,
  input  cpsp_wr_t              wr_i,
  output cpsp_rd_t              rd_o
);

  logic signed [PERR_W-1:0] pos_err_q [CHANNELS];
  logic signed [PINT_W-1:0] pos_int_q [CHANNELS];
  logic signed [SERR_W-1:0] spd_err_q [CHANNELS];
  logic signed [SINT_W-1:0] spd_int_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_err_q[i] <= '0;
        pos_int_q[i] <= '0;
        spd_err_q[i] <= '0;
        spd_int_q[i] <= '0;
      end
    end else begin
      if (wr_i.pos_err_we) begin
        pos_err_q[idx_i] <= wr_i.pos_err;
      end
      if (wr_i.pos_int_we) begin
        pos_int_q[idx_i] <= wr_i.pos_int;
      end
      if (wr_i.spd_we) begin
        spd_err_q[idx_i] <= wr_i.spd_err;
        spd_int_q[idx_i] <= wr_i.spd_int;
      end
    end
  end

  always_comb begin
    rd_o.pos_err = pos_err_q[idx_i];
    rd_o.pos_int = pos_int_q[idx_i];
    rd_o.spd_err = spd_err_q[idx_i];
    rd_o.spd_int = spd_int_q[idx_i];
  end

endmodule

/* src/cascaded_position_speed_pid.sv */
// Top level of the cascaded position and speed controller for several motor channels.
//
// Input transactions carry a channel, a setpoint, the measured angle and the measured
// speed; each one yields exactly one output transaction with the channel, the drive
// value and a flag that tells whether the drive was clamped. Gains and the mode are
// written through the register port; the user must do so only while no transaction is
// in flight, which the block itself does not enforce. One shared 25 x 33 bit multiplier
// with an accumulator does all gain products; every gain product takes two passes, one
// per operand limb, and the sequencer walks the steps in order. Cascade mode skips the
// integral product outside the integration band and adds a decay pass outside it or at
// zero error; speed-only mode skips the position loop; a nonexistent channel goes
// straight to the output step. in_ready_o is high only between transactions. The result
// sits in an output register: a stalled receiver holds it, and a new transaction is
// accepted and computed meanwhile, waiting in its last step until the register is free.
// Reset clears control registers, gains and every channel's state, not the datapath registers.
`timescale 1ns / 1ps

module cascaded_position_speed_pid import cpsp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CHAN_W-1:0]         channel_i,
  input  logic signed [SP_W-1:0]    setpoint_i,
  input  logic [ANGLE_W-1:0]        angle_i,
  input  logic signed [SPEED_W-1:0] speed_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [CHAN_W-1:0]         out_channel_o,
  output logic signed [DRIVE_W-1:0] drive_o,
  output logic                      clipped_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [GAIN_W-1:0]         cfg_wdata_i
);

  cpsp_state_e state_q, state_d;

  logic              mode_q;
  logic [GAIN_W-1:0] pos_kp_q, pos_ki_q, pos_kd_q;
  logic [GAIN_W-1:0] spd_kp_q, spd_ki_q, spd_kd_q;

  logic [CHAN_W-1:0]         ch_q, ch_d;
  logic signed [SP_W-1:0]    sp_q, sp_d;
  logic [ANGLE_W-1:0]        ang_q, ang_d;
  logic signed [SPEED_W-1:0] spd_q, spd_d;

  logic signed [PERR_W-1:0]     e_q, e_d;
  logic signed [PDE_W-1:0]      pde_q, pde_d;
  logic                         in_band_q, in_band_d;
  logic                         e_zero_q, e_zero_d;
  logic signed [PINT_W-1:0]     psum_q, psum_d;
  logic signed [PTGT_W-1:0]     tgt_q, tgt_d;
  logic signed [SERR_W-1:0]     serr_q, serr_d;
  logic signed [SDE_W-1:0]      sde_q, sde_d;
  logic signed [SINT_W-1:0]     sint_q, sint_d;
  logic signed [DRV_FULL_W-1:0] drv_full_q, drv_full_d;

  logic                      out_valid_q, out_valid_d;
  logic [CHAN_W-1:0]         out_ch_q, out_ch_d;
  logic signed [DRIVE_W-1:0] drive_q, drive_d;
  logic                      clipped_q, clipped_d;

  logic signed [PERR_W-1:0]   e_calc;
  logic signed [PINT_W:0]     psum_wide;
  logic signed [SDE_W-1:0]    sint_wide;
  logic                       do_decay;
  logic                       decay_fix;
  logic                       trunc_fix;

  cpsp_mac_op_t              mac_op;
  logic [GAIN_W-1:0]         mac_gain;
  logic signed [OPND_W-1:0]  mac_opnd;
  logic signed [ACC_W-1:0]   acc;
  logic                      frac;
  cpsp_wr_t                  wr;
  cpsp_rd_t                  rd;

  cpsp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .gain_i (mac_gain),
    .opnd_i (mac_opnd),
    .acc_o  (acc),
    .frac_o (frac)
  );

  cpsp_chan_state u_chan_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (CHAN_IDX_W'(ch_q)),
    .wr_i   (wr),
    .rd_o   (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      pos_kp_q <= '0;
      pos_ki_q <= '0;
      pos_kd_q <= '0;
      spd_kp_q <= '0;
      spd_ki_q <= '0;
      spd_kd_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CONTROL_MODE: mode_q   <= cfg_wdata_i[0];
        REG_POS_KP:       pos_kp_q <= cfg_wdata_i;
        REG_POS_KI:       pos_ki_q <= cfg_wdata_i;
        REG_POS_KD:       pos_kd_q <= cfg_wdata_i;
        REG_SPD_KP:       spd_kp_q <= cfg_wdata_i;
        REG_SPD_KI:       spd_ki_q <= cfg_wdata_i;
        REG_SPD_KD:       spd_kd_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    sp_q       <= sp_d;
    ang_q      <= ang_d;
    spd_q      <= spd_d;
    e_q        <= e_d;
    pde_q      <= pde_d;
    in_band_q  <= in_band_d;
    e_zero_q   <= e_zero_d;
    psum_q     <= psum_d;
    tgt_q      <= tgt_d;
    serr_q     <= serr_d;
    sde_q      <= sde_d;
    sint_q     <= sint_d;
    drv_full_q <= drv_full_d;
    out_ch_q   <= out_ch_d;
    drive_q    <= drive_d;
    clipped_q  <= clipped_d;
  end

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    sp_d        = sp_q;
    ang_d       = ang_q;
    spd_d       = spd_q;
    e_d         = e_q;
    pde_d       = pde_q;
    in_band_d   = in_band_q;
    e_zero_d    = e_zero_q;
    psum_d      = psum_q;
    tgt_d       = tgt_q;
    serr_d      = serr_q;
    sde_d       = sde_q;
    sint_d      = sint_q;
    drv_full_d  = drv_full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ch_d    = out_ch_q;
    drive_d     = drive_q;
    clipped_d   = clipped_q;
    mac_op      = '0;
    mac_gain    = '0;
    mac_opnd    = '0;
    wr          = '0;

    do_decay  = !in_band_q || e_zero_q;
    decay_fix = psum_q[PINT_W-1] && frac;
    trunc_fix = acc[ACC_W-1] && (|acc[FRAC_W-1:0]);
    e_calc    = PERR_W'(sp_q) - PERR_W'($signed({1'b0, ang_q}));
    psum_wide = (PINT_W+1)'(rd.pos_int) + ((PINT_W+1)'(e_q) <<< FRAC_W);
    sint_wide = SDE_W'(rd.spd_int) + SDE_W'(serr_q);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ch_d  = channel_i;
          sp_d  = setpoint_i;
          ang_d = angle_i;
          spd_d = speed_i;
          tgt_d = PTGT_W'(setpoint_i) <<< FRAC_W;
          if (int'(channel_i) >= CHANNELS) begin
            drv_full_d = '0;
            state_d    = ST_DONE;
          end else if (mode_q == MODE_SPEED_ONLY) begin
            state_d = ST_POS_WB;
          end else begin
            state_d = ST_POS_ERR;
          end
        end
      end
      ST_POS_ERR: begin
        e_d       = e_calc;
        pde_d     = PDE_W'(e_calc) - PDE_W'(rd.pos_err);
        in_band_d = (e_calc >= -POS_BAND) && (e_calc <= POS_BAND);
        e_zero_d  = (e_calc == '0);
        state_d   = ST_POS_SUM;
      end
      ST_POS_SUM: begin
        if (!in_band_q) begin
          psum_d = rd.pos_int;
        end else if (psum_wide > (PINT_W+1)'(PINT_MAX)) begin
          psum_d = PINT_MAX;
        end else if (psum_wide < (PINT_W+1)'(PINT_MIN)) begin
          psum_d = PINT_MIN;
        end else begin
          psum_d = PINT_W'(psum_wide);
        end
        state_d = ST_POS_KP_LO;
      end
      ST_POS_KP_LO: begin
        mac_op   = '{issue: 1'b1, hi: 1'b0, clr: 1'b1};
        mac_gain = pos_kp_q;
        mac_opnd = OPND_W'(e_q) <<< FRAC_W;
        state_d  = ST_POS_KP_HI;
      end
      ST_POS_KP_HI: begin
        mac_op   = '{issue: 1'b1, hi: 1'b1, clr: 1'b0};
        mac_gain = pos_kp_q;
        mac_opnd = OPND_W'(e_q) <<< FRAC_W;
        state_d  = in_band_q ? ST_POS_KI_LO : ST_POS_KD_LO;
      end
      ST_POS_KI_LO: begin
        mac_op   = '{issue: 1'b1, hi: 1'b0, clr: 1'b0};
        mac_gain = pos_ki_q;
        mac_opnd = OPND_W'(psum_q);
        state_d  = ST_POS_KI_HI;
      end
      ST_POS_KI_HI: begin
        mac_op   = '{issue: 1'b1, hi: 1'b1, clr: 1'b0};
        mac_gain = pos_ki_q;
        mac_opnd = OPND_W'(psum_q);
        state_d  = ST_POS_KD_LO;
      end
      ST_POS_KD_LO: begin
        mac_op   = '{issue: 1'b1, hi: 1'b0, clr: 1'b0};
        mac_gain = pos_kd_q;
        mac_opnd = OPND_W'(pde_q) <<< FRAC_W;
        state_d  = ST_POS_KD_HI;
      end
      ST_POS_KD_HI: begin
        mac_op   = '{issue: 1'b1, hi: 1'b1, clr: 1'b0};
        mac_gain = pos_kd_q;
        mac_opnd = OPND_W'(pde_q) <<< FRAC_W;
        state_d  = ST_POS_DRAIN;
      end
      ST_POS_DRAIN: begin
        // The integral decay starts here and accumulates behind the loop output.
        mac_op   = '{issue: do_decay, hi: 1'b0, clr: 1'b1};
        mac_gain = e_zero_q ? DECAY_ZERO : DECAY_OUT;
        mac_opnd = OPND_W'(psum_q);
        state_d  = ST_POS_OUT;
      end
      ST_POS_OUT: begin
        mac_op   = '{issue: do_decay, hi: 1'b1, clr: 1'b0};
        mac_gain = e_zero_q ? DECAY_ZERO : DECAY_OUT;
        mac_opnd = OPND_W'(psum_q);
        if (acc > ACC_W'(PTGT_MAX)) begin
          tgt_d = PTGT_MAX;
        end else if (acc < ACC_W'(PTGT_MIN)) begin
          tgt_d = PTGT_MIN;
        end else begin
          tgt_d = PTGT_W'(acc);
        end
        state_d = do_decay ? ST_DEC_DRAIN : ST_POS_WB;
      end
      ST_DEC_DRAIN: begin
        state_d = ST_POS_WB;
      end
      ST_POS_WB: begin
        wr.pos_err_we = (mode_q != MODE_SPEED_ONLY);
        wr.pos_err    = e_q;
        wr.pos_int_we = 1'b1;
        if (mode_q == MODE_SPEED_ONLY) begin
          wr.pos_int = '0;
        end else if (do_decay) begin
          wr.pos_int = PINT_W'(acc) + PINT_W'(decay_fix);
        end else begin
          wr.pos_int = psum_q;
        end
        state_d = ST_SPD_ERR;
      end
      ST_SPD_ERR: begin
        serr_d  = SERR_W'(tgt_q) - (SERR_W'(spd_q) <<< FRAC_W);
        state_d = ST_SPD_SUM;
      end
      ST_SPD_SUM: begin
        sde_d = SDE_W'(serr_q) - SDE_W'(rd.spd_err);
        if (sint_wide > SDE_W'(SINT_LIM)) begin
          sint_d = SINT_LIM;
        end else if (sint_wide < SDE_W'(SINT_NEG)) begin
          sint_d = SINT_NEG;
        end else begin
          sint_d = SINT_W'(sint_wide);
        end
        state_d = ST_SPD_KP_LO;
      end
      ST_SPD_KP_LO: begin
        wr.spd_we  = 1'b1;
        wr.spd_err = serr_q;
        wr.spd_int = sint_q;
        mac_op     = '{issue: 1'b1, hi: 1'b0, clr: 1'b1};
        mac_gain   = spd_kp_q;
        mac_opnd   = OPND_W'(serr_q);
        state_d    = ST_SPD_KP_HI;
      end
      ST_SPD_KP_HI: begin
        mac_op   = '{issue: 1'b1, hi: 1'b1, clr: 1'b0};
        mac_gain = spd_kp_q;
        mac_opnd = OPND_W'(serr_q);
        state_d  = ST_SPD_KI_LO;
      end
      ST_SPD_KI_LO: begin
        mac_op   = '{issue: 1'b1, hi: 1'b0, clr: 1'b0};
        mac_gain = spd_ki_q;
        mac_opnd = OPND_W'(sint_q);
        state_d  = ST_SPD_KI_HI;
      end
      ST_SPD_KI_HI: begin
        mac_op   = '{issue: 1'b1, hi: 1'b1, clr: 1'b0};
        mac_gain = spd_ki_q;
        mac_opnd = OPND_W'(sint_q);
        state_d  = ST_SPD_KD_LO;
      end
      ST_SPD_KD_LO: begin
        mac_op   = '{issue: 1'b1, hi: 1'b0, clr: 1'b0};
        mac_gain = spd_kd_q;
        mac_opnd = OPND_W'(sde_q);
        state_d  = ST_SPD_KD_HI;
      end
      ST_SPD_KD_HI: begin
        mac_op   = '{issue: 1'b1, hi: 1'b1, clr: 1'b0};
        mac_gain = spd_kd_q;
        mac_opnd = OPND_W'(sde_q);
        state_d  = ST_SPD_DRAIN;
      end
      ST_SPD_DRAIN: begin
        state_d = ST_FINAL;
      end
      ST_FINAL: begin
        drv_full_d = DRV_FULL_W'(acc >>> FRAC_W) + DRV_FULL_W'(trunc_fix);
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ch_d    = ch_q;
          if (drv_full_q > DRV_FULL_W'(DRIVE_LIM)) begin
            drive_d   = DRIVE_LIM;
            clipped_d = 1'b1;
          end else if (drv_full_q < DRV_FULL_W'(DRIVE_NEG)) begin
            drive_d   = DRIVE_NEG;
            clipped_d = 1'b1;
          end else begin
            drive_d   = DRIVE_W'(drv_full_q);
            clipped_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign drive_o       = drive_q;
  assign clipped_o     = clipped_q;

endmodule

/* src/cpsp_checker.sv */
// Port-level checker of the cascaded position and speed controller and its bind.
`timescale 1ns / 1ps
`include "cascaded_position_speed_pid_defines.svh"

module cpsp_checker import cpsp_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [DRIVE_W-1:0] drive_o,
  input logic                      clipped_o
);

  `CPSP_ASSERT_HOLDS(a_drive_range, out_valid_o, (drive_o <= DRIVE_LIM) && (drive_o >= DRIVE_NEG), "drive value outside its limit")
  `CPSP_ASSERT_HOLDS(a_clip_at_limit, out_valid_o && clipped_o, (drive_o == DRIVE_LIM) || (drive_o == DRIVE_NEG), "clipped flag set away from the limit")
  `CPSP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready stayed high after an input transaction")
  `CPSP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(drive_o) && $stable(clipped_o), "stalled result changed")

endmodule

bind cascaded_position_speed_pid cpsp_checker u_cpsp_checker (.*);
